[hw/rtl/mtg_pkg.sv]
package mtg_pkg;

	localparam int STATE_DEPTH   = 624;
	localparam int MIDDLE_OFFSET = 397;
	localparam int WORD_W        = 32;
	localparam int IDX_W         = $clog2(STATE_DEPTH);

	localparam logic [WORD_W-1:0] MATRIX_A   = 32'h9908_B0DF;
	localparam logic [WORD_W-1:0] TEMPER_B   = 32'h9D2C_5680;
	localparam logic [WORD_W-1:0] TEMPER_C   = 32'hEFC6_0000;
	localparam logic [WORD_W-1:0] INIT_MULT  = 32'd1812433253;
	localparam logic [WORD_W-1:0] UPPER_MASK = 32'h8000_0000;
	localparam logic [WORD_W-1:0] LOWER_MASK = 32'h7FFF_FFFF;
	localparam logic [WORD_W-1:0] SEED_RESET = 32'd5489;

	// words the control logic reads from fixed places in the chain
	typedef struct packed {
		logic [WORD_W-1:0] head;   // x[k]
		logic [WORD_W-1:0] second; // x[k+1]
		logic [WORD_W-1:0] mid;    // x[k+MIDDLE_OFFSET]
		logic [WORD_W-1:0] tail;   // most recent word shifted in
	} taps_t;

	function automatic logic [WORD_W-1:0] twist_word(input taps_t t);
		logic [WORD_W-1:0] x;
		logic [WORD_W-1:0] xa;
		x  = (t.head & UPPER_MASK) | (t.second & LOWER_MASK);
		xa = x >> 1;
		if (x[0]) begin
			xa = xa ^ MATRIX_A;
		end
		return t.mid ^ xa;
	endfunction

	function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
		logic [WORD_W-1:0] y;
		y = w ^ (w >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

[hw/rtl/mtg_cell.sv]
// one state word; takes its neighbor's word on every shift
module mtg_cell (
	input  logic                          clk,
	input  logic                          shift_en,
	input  logic [mtg_pkg::WORD_W-1:0]    d,
	output logic [mtg_pkg::WORD_W-1:0]    q
);

	logic [mtg_pkg::WORD_W-1:0] word_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			word_q <= d;
		end
	end

	assign q = word_q;

endmodule

[hw/rtl/mtg_chain.sv]
// row of state cells; words move toward cell 0, new words enter at the far end
module mtg_chain (
	input  logic                          clk,
	input  logic                          shift_en,
	input  logic [mtg_pkg::WORD_W-1:0]    tail_in,
	output mtg_pkg::taps_t                taps
);

	logic [mtg_pkg::WORD_W-1:0] link [mtg_pkg::STATE_DEPTH+1];

	assign link[mtg_pkg::STATE_DEPTH] = tail_in;

	for (genvar i = 0; i < mtg_pkg::STATE_DEPTH; i++) begin : g_cell
		mtg_cell u_cell (
			.clk      (clk),
			.shift_en (shift_en),
			.d        (link[i+1]),
			.q        (link[i])
		);
	end

	assign taps.head   = link[0];
	assign taps.second = link[1];
	assign taps.mid    = link[mtg_pkg::MIDDLE_OFFSET];
	assign taps.tail   = link[mtg_pkg::STATE_DEPTH-1];

endmodule

[hw/rtl/mersenne_twister_generator.sv]
// MT19937 generator. The 624-word state sits in a chain of cells that shifts one word per
// draw: each beat twists the head word with its neighbor and the word 397 places on, the
// result enters the far end and its tempered value is the output. A beat with restart=0
// is accepted whenever in_ready is high, so with in_valid and out_ready held high one word
// per cycle comes out. After reset the chain is filled from seed_value one word per cycle
// through the seeding multiplier with in_ready low. A beat with restart=1 refills the chain
// the same way and then draws its word, so in_ready stays low through the refill and the
// draw, and its word is presented once both are done. A write to seed_value takes effect
// at the next restart.
module mersenne_twister_generator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mtg_pkg::WORD_W-1:0]    cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          restart,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [mtg_pkg::WORD_W-1:0]    random_word
);

	typedef enum logic {
		ST_SEED,
		ST_RUN
	} state_t;

	state_t                       state_q;
	logic [mtg_pkg::IDX_W-1:0]    seed_idx_q;
	logic                         pending_q;
	logic                         out_valid_q;
	logic [mtg_pkg::WORD_W-1:0]   out_word_q;
	logic [mtg_pkg::WORD_W-1:0]   seed_q;

	mtg_pkg::taps_t               taps;
	logic [mtg_pkg::WORD_W-1:0]   new_word;
	logic [mtg_pkg::WORD_W-1:0]   seed_word;
	logic [mtg_pkg::WORD_W-1:0]   tail_in;
	logic                         in_accept;
	logic                         draw_go;
	logic                         seed_last;
	logic                         shift_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= mtg_pkg::SEED_RESET;
		end else if (cfg_we) begin
			seed_q <= cfg_wdata;
		end
	end

	assign in_ready  = (state_q == ST_RUN) && !pending_q && (!out_valid_q || out_ready);
	assign in_accept = in_valid && in_ready;
	// a restart beat draws once seeding is done
	assign draw_go   = (state_q == ST_RUN) && (pending_q || (in_accept && !restart));
	assign seed_last = (seed_idx_q == mtg_pkg::IDX_W'(mtg_pkg::STATE_DEPTH - 1));
	assign shift_en  = (state_q == ST_SEED) || draw_go;

	assign new_word  = mtg_pkg::twist_word(taps);
	assign seed_word = (seed_idx_q == '0) ? seed_q :
		(mtg_pkg::INIT_MULT * (taps.tail ^ (taps.tail >> 30)))
		+ mtg_pkg::WORD_W'(seed_idx_q);
	assign tail_in   = (state_q == ST_SEED) ? seed_word : new_word;

	mtg_chain u_chain (
		.clk      (clk),
		.shift_en (shift_en),
		.tail_in  (tail_in),
		.taps     (taps)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SEED;
			seed_idx_q  <= '0;
			pending_q   <= 1'b0;
			out_valid_q <= 1'b0;
			out_word_q  <= '0;
		end else begin
			unique case (state_q)
				ST_SEED: begin
					seed_idx_q <= seed_idx_q + mtg_pkg::IDX_W'(1);
					if (seed_last) begin
						seed_idx_q <= '0;
						state_q    <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (in_accept && restart) begin
						state_q   <= ST_SEED;
						pending_q <= 1'b1;
					end else if (pending_q) begin
						pending_q <= 1'b0;
					end
				end
				default: state_q <= ST_SEED;
			endcase

			if (draw_go) begin
				out_valid_q <= 1'b1;
				out_word_q  <= mtg_pkg::temper(new_word);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign random_word = out_word_q;

	a_seed_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SEED |-> seed_idx_q < mtg_pkg::IDX_W'(mtg_pkg::STATE_DEPTH))
		else $error("seed index past end of chain");

	a_restart_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && restart |=> !in_ready && state_q == ST_SEED)
		else $error("restart beat did not start seeding");

	a_pending_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN && pending_q |-> !out_valid_q)
		else $error("output slot busy at pending draw");

	a_pending_clears: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN && pending_q |=> !pending_q && out_valid_q)
		else $error("pending draw not delivered");

	a_idle_seed_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> seed_idx_q == '0)
		else $error("seed index not cleared after seeding");

endmodule
